// ===== sv/epoc_pkg.sv =====
`default_nettype none
// ============================================================================
// epoc_pkg - shared types and constants of the ellipse pair overlap counter
// Request and result layouts, the job record passed front to back, and the
// whole-degree sine table.
// ============================================================================
package epoc_pkg;

    localparam int COORD_W = 12;
    localparam int AXIS_W  = 8;
    localparam int ANGLE_W = 15;
    localparam int CNT_W   = 19;
    localparam int AREA_W  = 23;
    localparam int TRIG_W  = 17;   // signed sine/cosine, 15 fraction bits
    localparam int POS_W   = 16;   // signed pixel coordinate
    localparam int SIZE_W  = 11;   // box width/height
    localparam int QPOS_W  = 13;   // position inside one quadrant

    localparam logic [ANGLE_W-1:0] ANGLE_FULL    = 15'd23040;  // 360 degrees
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 15'd5760;   // 90 degrees
    localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 15'd11520;
    localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 15'd17280;
    localparam logic [17:0]        PI_Q16        = 18'd205887;
    localparam int                 LANE_LAT      = 7;

    typedef struct packed {
        logic [COORD_W-1:0] center1_x;
        logic [COORD_W-1:0] center1_y;
        logic [AXIS_W-1:0]  axis1_a;
        logic [AXIS_W-1:0]  axis1_b;
        logic [ANGLE_W-1:0] angle1;
        logic [COORD_W-1:0] center2_x;
        logic [COORD_W-1:0] center2_y;
        logic [AXIS_W-1:0]  axis2_a;
        logic [AXIS_W-1:0]  axis2_b;
        logic [ANGLE_W-1:0] angle2;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]  overlap_count;
        logic [AREA_W-1:0] union_area_q4;
    } t_res;

    // per-ellipse constants used by the inside test
    typedef struct packed {
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
        logic [15:0]              a2;
        logic [15:0]              b2;
        logic [31:0]              ab2;
    } t_lane;

    typedef struct packed {
        t_lane                    e1;
        t_lane                    e2;
        logic signed [POS_W-1:0]  x0;
        logic signed [POS_W-1:0]  y0;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic                     scan;
        logic [AREA_W-1:0]        area0;
    } t_job;

    function automatic logic [15:0] sin_deg(input logic [6:0] d);
        logic [15:0] v;
        unique case (d)
            7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
            7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
            7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
            7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
            7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
            7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
            7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
            7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
            7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
            7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
            7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
            7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
            7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
            7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
            7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
            7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
            7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
            7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
            7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
            7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
            7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
            7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
            7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
            7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
            7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/epoc_fifo.sv =====
`default_nettype none
// ============================================================================
// epoc_fifo - two-entry job queue
// Decouples the setup front end from the pixel scan back end.
// ============================================================================
module epoc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  epoc_pkg::t_job      i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output epoc_pkg::t_job      o_data,
    output logic                o_empty
);
    import epoc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/epoc_front.sv =====
`default_nettype none
// ============================================================================
// epoc_front - request setup
// Takes one request, works out trig and bounding box for each ellipse in
// turn on one shared datapath, then the box overlap, and queues the scan job.
// ============================================================================
module epoc_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  epoc_pkg::t_req  i_req,
    output logic            o_push,
    output epoc_pkg::t_job  o_job,
    input  wire logic       i_full
);
    import epoc_pkg::*;

    typedef struct packed {
        t_lane                   lane;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic [SIZE_W-1:0]       bw;
        logic [SIZE_W-1:0]       bh;
    } t_ebox;

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_ANG  = 4'd1;
    localparam logic [3:0] F_QUAD = 4'd2;
    localparam logic [3:0] F_TRIG = 4'd3;
    localparam logic [3:0] F_SQ   = 4'd4;
    localparam logic [3:0] F_MUL  = 4'd5;
    localparam logic [3:0] F_SUM  = 4'd6;
    localparam logic [3:0] F_SQRT = 4'd7;
    localparam logic [3:0] F_BOX  = 4'd8;
    localparam logic [3:0] F_DEC1 = 4'd9;
    localparam logic [3:0] F_DEC2 = 4'd10;
    localparam logic [3:0] F_PUSH = 4'd11;

    function automatic logic [16:0] qsin(input logic [QPOS_W-1:0] p);
        logic [6:0]  d;
        logic [5:0]  f;
        logic [15:0] t0;
        logic [15:0] dt;
        logic [21:0] v;
        d  = p[12:6];
        f  = p[5:0];
        t0 = sin_deg(d);
        dt = sin_deg(d + 7'd1) - t0;
        if (d >= 7'd90) v = {t0, 6'd0};
        else            v = {t0, 6'd0} + ({6'd0, dt} * {16'd0, f});
        return 17'(({1'b0, v} + 23'd32) >> 6);
    endfunction

    function automatic logic [15:0] magn(input logic signed [TRIG_W-1:0] x);
        logic [TRIG_W-1:0] m;
        m = x[TRIG_W-1] ? 17'(-x) : 17'(x);
        return m[15:0];
    endfunction

    logic [3:0]               r_state;
    logic                     r_sel;
    t_req                     r_req;
    logic [ANGLE_W-1:0]       r_rot;
    logic [1:0]               r_quad;
    logic [QPOS_W-1:0]        r_pos;
    logic signed [TRIG_W-1:0] r_s;
    logic signed [TRIG_W-1:0] r_c;
    logic [16:0]              r_c2;
    logic [16:0]              r_s2;
    logic [15:0]              r_a2;
    logic [15:0]              r_b2;
    logic [32:0]              r_ac;
    logic [32:0]              r_bs;
    logic [32:0]              r_as;
    logic [32:0]              r_bc;
    logic [33:0]              r_xrem;
    logic [33:0]              r_yrem;
    logic [33:0]              r_xroot;
    logic [33:0]              r_yroot;
    logic [33:0]              r_bit;
    t_ebox                    r_ell [2];
    logic                     r_hit;
    logic [21:0]              r_area1;
    logic [21:0]              r_area2;
    logic [16:0]              r_absum;
    t_job                     r_job;

    // fields of the ellipse in work
    logic [COORD_W-1:0] cur_cx;
    logic [COORD_W-1:0] cur_cy;
    logic [AXIS_W-1:0]  cur_a;
    logic [AXIS_W-1:0]  cur_b;
    logic [ANGLE_W-1:0] cur_ang;

    always_comb begin
        cur_cx  = r_sel ? r_req.center2_x : r_req.center1_x;
        cur_cy  = r_sel ? r_req.center2_y : r_req.center1_y;
        cur_a   = r_sel ? r_req.axis2_a   : r_req.axis1_a;
        cur_b   = r_sel ? r_req.axis2_b   : r_req.axis1_b;
        cur_ang = r_sel ? r_req.angle2    : r_req.angle1;
    end

    // trig and box helpers
    logic [16:0]      lo_v;
    logic [16:0]      hi_v;
    logic [15:0]      cm;
    logic [15:0]      sm;
    logic [34:0]      xsum;
    logic [34:0]      ysum;
    logic [16:0]      lx;
    logic [16:0]      ly;
    logic signed [22:0] tx;
    logic signed [22:0] ty;
    logic [17:0]      wx;
    logic [17:0]      wy;
    t_ebox            e1;
    t_ebox            e2;

    always_comb begin
        lo_v = qsin(r_pos);
        hi_v = qsin(QPOS_W'(ANGLE_QUARTER) - r_pos);
        cm   = magn(r_c);
        sm   = magn(r_s);
        xsum = {1'b0, r_xroot} + {1'b0, r_bit};
        ysum = {1'b0, r_yroot} + {1'b0, r_bit};
        lx   = r_xroot[16:0];
        ly   = r_yroot[16:0];
        wx   = {lx, 1'b0} + 18'd128;
        wy   = {ly, 1'b0} + 18'd128;
        tx   = $signed({3'd0, cur_cx, 8'h80}) - $signed({6'd0, lx});
        ty   = $signed({3'd0, cur_cy, 8'h80}) - $signed({6'd0, ly});
        e1   = r_ell[0];
        e2   = r_ell[1];
    end

    assign o_req_ready = (r_state == F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_sel   <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_sel   <= 1'b0;
                        r_state <= F_ANG;
                    end
                end
                F_ANG: begin
                    r_rot   <= (cur_ang >= ANGLE_FULL) ? cur_ang - ANGLE_FULL : cur_ang;
                    r_state <= F_QUAD;
                end
                F_QUAD: begin
                    priority if (r_rot >= ANGLE_3QUART) begin
                        r_quad <= 2'd3;
                        r_pos  <= QPOS_W'(r_rot - ANGLE_3QUART);
                    end else if (r_rot >= ANGLE_HALF) begin
                        r_quad <= 2'd2;
                        r_pos  <= QPOS_W'(r_rot - ANGLE_HALF);
                    end else if (r_rot >= ANGLE_QUARTER) begin
                        r_quad <= 2'd1;
                        r_pos  <= QPOS_W'(r_rot - ANGLE_QUARTER);
                    end else begin
                        r_quad <= 2'd0;
                        r_pos  <= QPOS_W'(r_rot);
                    end
                    r_state <= F_TRIG;
                end
                F_TRIG: begin
                    unique case (r_quad)
                        2'd0: begin
                            r_s <= $signed(lo_v);  r_c <= $signed(hi_v);
                        end
                        2'd1: begin
                            r_s <= $signed(hi_v);  r_c <= -$signed(lo_v);
                        end
                        2'd2: begin
                            r_s <= -$signed(lo_v); r_c <= -$signed(hi_v);
                        end
                        default: begin
                            r_s <= -$signed(hi_v); r_c <= $signed(lo_v);
                        end
                    endcase
                    r_state <= F_SQ;
                end
                F_SQ: begin
                    r_c2    <= 17'(({16'd0, cm} * {16'd0, cm} + 32'd8192) >> 14);
                    r_s2    <= 17'(({16'd0, sm} * {16'd0, sm} + 32'd8192) >> 14);
                    r_a2    <= cur_a * cur_a;
                    r_b2    <= cur_b * cur_b;
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    r_ac    <= {1'b0, r_a2} * r_c2;
                    r_bs    <= {1'b0, r_b2} * r_s2;
                    r_as    <= {1'b0, r_a2} * r_s2;
                    r_bc    <= {1'b0, r_b2} * r_c2;
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    r_xrem  <= {1'b0, r_ac} + {1'b0, r_bs};
                    r_yrem  <= {1'b0, r_as} + {1'b0, r_bc};
                    r_xroot <= 34'd0;
                    r_yroot <= 34'd0;
                    r_bit   <= 34'h1_0000_0000;
                    r_state <= F_SQRT;
                end
                F_SQRT: begin
                    // one result bit per cycle for both roots
                    if ({1'b0, r_xrem} >= xsum) begin
                        r_xrem  <= 34'({1'b0, r_xrem} - xsum);
                        r_xroot <= (r_xroot >> 1) + r_bit;
                    end else begin
                        r_xroot <= r_xroot >> 1;
                    end
                    if ({1'b0, r_yrem} >= ysum) begin
                        r_yrem  <= 34'({1'b0, r_yrem} - ysum);
                        r_yroot <= (r_yroot >> 1) + r_bit;
                    end else begin
                        r_yroot <= r_yroot >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= F_BOX;
                end
                F_BOX: begin
                    r_ell[r_sel].lane.cx  <= cur_cx;
                    r_ell[r_sel].lane.cy  <= cur_cy;
                    r_ell[r_sel].lane.s   <= r_s;
                    r_ell[r_sel].lane.c   <= r_c;
                    r_ell[r_sel].lane.a2  <= r_a2;
                    r_ell[r_sel].lane.b2  <= r_b2;
                    r_ell[r_sel].lane.ab2 <= r_a2 * r_b2;
                    r_ell[r_sel].bw <= {1'b0, wx[17:8]};
                    r_ell[r_sel].bh <= {1'b0, wy[17:8]};
                    r_ell[r_sel].bx <= {tx[22], tx[22:8]};
                    r_ell[r_sel].by <= {ty[22], ty[22:8]};
                    if (r_sel) begin
                        r_state <= F_DEC1;
                    end else begin
                        r_sel   <= 1'b1;
                        r_state <= F_ANG;
                    end
                end
                F_DEC1: begin
                    r_hit <= ($signed({e1.bx[15], e1.bx}) <=
                              $signed({e2.bx[15], e2.bx}) + $signed({6'd0, e2.bw})) &&
                             ($signed({e2.bx[15], e2.bx}) <=
                              $signed({e1.bx[15], e1.bx}) + $signed({6'd0, e1.bw})) &&
                             ($signed({e1.by[15], e1.by}) <=
                              $signed({e2.by[15], e2.by}) + $signed({6'd0, e2.bh})) &&
                             ($signed({e2.by[15], e2.by}) <=
                              $signed({e1.by[15], e1.by}) + $signed({6'd0, e1.bh}));
                    r_area1 <= e1.bw * e1.bh;
                    r_area2 <= e2.bw * e2.bh;
                    r_absum <= {1'b0, 16'(r_req.axis1_a) * 16'(r_req.axis1_b)} +
                               {1'b0, 16'(r_req.axis2_a) * 16'(r_req.axis2_b)};
                    r_state <= F_DEC2;
                end
                F_DEC2: begin
                    r_job.e1 <= e1.lane;
                    r_job.e2 <= e2.lane;
                    // scan the smaller box, the first one on a tie
                    if (r_area1 > r_area2) begin
                        r_job.x0 <= e2.bx;
                        r_job.y0 <= e2.by;
                        r_job.w  <= e2.bw;
                        r_job.h  <= e2.bh;
                        r_job.scan <= r_hit && (e2.bw != '0) && (e2.bh != '0);
                    end else begin
                        r_job.x0 <= e1.bx;
                        r_job.y0 <= e1.by;
                        r_job.w  <= e1.bw;
                        r_job.h  <= e1.bh;
                        r_job.scan <= r_hit && (e1.bw != '0) && (e1.bh != '0);
                    end
                    r_job.area0 <= AREA_W'(({19'd0, r_absum} * {18'd0, PI_Q16} +
                                            36'd2048) >> 12);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/epoc_inside.sv =====
`default_nettype none
// ============================================================================
// epoc_inside - pipelined point-in-ellipse test
// Evaluates b2*u*u + a2*v*v <= a2*b2*2^30 exactly, one pixel per cycle,
// through registered offsets, rotation, squares, scaling, sums and compare.
// ============================================================================
module epoc_inside (
    input  wire logic                           i_clk,
    input  wire logic signed [epoc_pkg::POS_W-1:0] i_px,
    input  wire logic signed [epoc_pkg::POS_W-1:0] i_py,
    input  epoc_pkg::t_lane                     i_lane,
    output logic                                o_inside
);
    import epoc_pkg::*;

    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic signed [33:0] r_xc;
    logic signed [33:0] r_ys;
    logic signed [33:0] r_xs;
    logic signed [33:0] r_yc;
    logic [29:0]        r_au;
    logic [29:0]        r_av;
    logic [59:0]        r_usq;
    logic [59:0]        r_vsq;
    logic [45:0]        r_uh;
    logic [45:0]        r_ul;
    logic [45:0]        r_vh;
    logic [45:0]        r_vl;
    logic [76:0]        r_tu;
    logic [76:0]        r_tv;
    logic               r_in;

    logic signed [34:0] u;
    logic signed [34:0] v;
    logic [34:0]        um;
    logic [34:0]        vm;
    logic [77:0]        lhs;
    logic [77:0]        rhs;

    always_comb begin
        u   = 35'(r_xc) + 35'(r_ys);
        v   = 35'(r_xs) - 35'(r_yc);
        um  = u[34] ? 35'(-u) : 35'(u);
        vm  = v[34] ? 35'(-v) : 35'(v);
        lhs = {1'b0, r_tu} + {1'b0, r_tv};
        rhs = {16'd0, i_lane.ab2, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= 17'(i_px) - $signed({5'd0, i_lane.cx});
        r_dy  <= 17'(i_py) - $signed({5'd0, i_lane.cy});
        r_xc  <= r_dx * i_lane.c;
        r_ys  <= r_dy * i_lane.s;
        r_xs  <= r_dx * i_lane.s;
        r_yc  <= r_dy * i_lane.c;
        r_au  <= um[29:0];
        r_av  <= vm[29:0];
        r_usq <= r_au * r_au;
        r_vsq <= r_av * r_av;
        r_uh  <= r_usq[59:30] * i_lane.b2;
        r_ul  <= r_usq[29:0]  * i_lane.b2;
        r_vh  <= r_vsq[59:30] * i_lane.a2;
        r_vl  <= r_vsq[29:0]  * i_lane.a2;
        r_tu  <= {1'b0, r_uh, 30'd0} + {31'd0, r_ul};
        r_tv  <= {1'b0, r_vh, 30'd0} + {31'd0, r_vl};
        r_in  <= (lhs <= rhs);
    end

    assign o_inside = r_in;

endmodule
`default_nettype wire

// ===== sv/epoc_back.sv =====
`default_nettype none
// ============================================================================
// epoc_back - pixel scan and result
// Pops a job, walks the chosen box one pixel per cycle through two inside
// lanes if scan is set, counts pixels inside both, and forms the result.
// ============================================================================
module epoc_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  epoc_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output epoc_pkg::t_res  o_res
);
    import epoc_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_SCAN  = 2'd1;
    localparam logic [1:0] B_DRAIN = 2'd2;

    logic [1:0]          r_state;
    t_job                r_job;
    logic [SIZE_W-1:0]   r_ix;
    logic [SIZE_W-1:0]   r_iy;
    logic [LANE_LAT-1:0] r_vld;
    logic [19:0]         r_cnt;
    logic                r_res_valid;
    t_res                r_res;

    logic                    issue;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    in1;
    logic                    in2;
    logic [23:0]             cnt16;

    always_comb begin
        issue = (r_state == B_SCAN);
        px    = r_job.x0 + $signed({5'd0, r_ix});
        py    = r_job.y0 + $signed({5'd0, r_iy});
        cnt16 = {r_cnt, 4'd0};
    end

    assign o_pop       = (r_state == B_IDLE) && !i_empty && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    epoc_inside u_lane1 (
        .i_clk    (i_clk),
        .i_px     (px),
        .i_py     (py),
        .i_lane   (r_job.e1),
        .o_inside (in1)
    );

    epoc_inside u_lane2 (
        .i_clk    (i_clk),
        .i_px     (px),
        .i_py     (py),
        .i_lane   (r_job.e2),
        .o_inside (in2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_vld       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_vld <= {r_vld[LANE_LAT-2:0], issue};
            if (r_vld[LANE_LAT-1] && in1 && in2) r_cnt <= r_cnt + 20'd1;
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_ix    <= '0;
                        r_iy    <= '0;
                        r_cnt   <= '0;
                        r_state <= i_job.scan ? B_SCAN : B_DRAIN;
                    end
                end
                B_SCAN: begin
                    if (r_iy == r_job.h - SIZE_W'(1)) begin
                        r_iy <= '0;
                        if (r_ix == r_job.w - SIZE_W'(1)) r_state <= B_DRAIN;
                        else                              r_ix <= r_ix + SIZE_W'(1);
                    end else begin
                        r_iy <= r_iy + SIZE_W'(1);
                    end
                end
                B_DRAIN: begin
                    if (r_vld == '0) begin
                        r_res.overlap_count <= (r_cnt > 20'h7FFFF) ? 19'h7FFFF :
                                               r_cnt[CNT_W-1:0];
                        r_res.union_area_q4 <= (cnt16 > {1'b0, r_job.area0}) ? '0 :
                                               AREA_W'({1'b0, r_job.area0} - cnt16);
                        r_res_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/ellipse_pair_overlap_counter_unit.sv =====
`default_nettype none
// ============================================================================
// ellipse_pair_overlap_counter_unit - overlap count of two rotated ellipses
// Counts integer pixels inside both ellipses over the smaller bounding box
// and reports the union area estimate.
// ============================================================================
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  request  | i_req_valid / o_req_ready  | i_req  (two centres, axes, angles)
//  result   | o_res_valid / i_res_ready  | o_res  (overlap count, union area)
//
//  Setup handles the two ellipses of a request in turn on one datapath,
//  its 17-step square root being the longest step; the scan then walks
//  the smaller box after the job pop, one pixel per cycle through the
//  two 7-stage inside lanes, then drains them and forms the result.
//  Disjoint boxes skip the scan.
//  Reset: synchronous, active low; clears all control state and the queue.
//  Stalls: a two-entry job queue lets setup of the next request run while
//  the current one scans; a held result stops only the next job pop.
//
module ellipse_pair_overlap_counter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  epoc_pkg::t_req  i_req,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output epoc_pkg::t_res  o_res
);
    import epoc_pkg::*;

    // front to queue
    logic push;
    logic full;
    t_job push_job;
    // queue to back
    logic pop;
    logic empty;
    t_job pop_job;

    // setup: trig, boxes, overlap decision
    epoc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    // hold jobs between setup and scan
    epoc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    // scan the box and drive the result register
    epoc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
